// ===== sv/cim_pkg.sv =====
// ----------------------------------------------------------------------------
// cim_pkg
// Shared widths, codes and the sequencer state type of the centroid
// interaction max-sum scorer.
// ----------------------------------------------------------------------------
package cim_pkg;

  // transaction field widths
  localparam int CMD_W     = 1;
  localparam int QIDX_W    = 5;
  localparam int CENT_W    = 12;
  localparam int SCORE_W   = 16;
  localparam int DOC_W     = 21;
  localparam int ACTIVE_W  = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CODE = 1'b1;

  // reset value of the active query count
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd32;

  // most negative Q2.13 score, start value of every running maximum
  localparam logic signed [SCORE_W-1:0] MOST_NEG = 16'sh8000;

  // output saturation bounds
  localparam logic signed [31:0] SUM_MAX = 32'sd1048575;
  localparam logic signed [31:0] SUM_MIN = -32'sd1048576;

  // document epoch tag width of the seen-mark memory
  localparam int EPOCH_W = 8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SEEN_RD,
    S_SEEN_CHK,
    S_UPD,
    S_SUM,
    S_DONE
  } state_t;

endpackage

// ===== sv/cim_in_if.sv =====
// ----------------------------------------------------------------------------
// cim_in_if
// Input channel: load and document code transactions.
// ----------------------------------------------------------------------------
interface cim_in_if;
  logic                           valid;
  logic                           ready;
  logic [cim_pkg::CMD_W-1:0]      cmd;
  logic [cim_pkg::QIDX_W-1:0]     query_index;
  logic [cim_pkg::CENT_W-1:0]     centroid;
  logic signed [cim_pkg::SCORE_W-1:0] score;
  logic                           last_code;

  modport source (output valid, cmd, query_index, centroid, score, last_code,
                  input ready);
  modport sink   (input valid, cmd, query_index, centroid, score, last_code,
                  output ready);
endinterface

// ===== sv/cim_out_if.sv =====
// ----------------------------------------------------------------------------
// cim_out_if
// Result channel: one match sum per document.
// ----------------------------------------------------------------------------
interface cim_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cim_pkg::DOC_W-1:0]   match_sum;

  modport source (output valid, match_sum, input ready);
  modport sink   (input valid, match_sum, output ready);
endinterface

// ===== sv/cim_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cim_cfg_if
// Configuration write channel for the active query count.
// ----------------------------------------------------------------------------
interface cim_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cim_pkg::ACTIVE_W-1:0]      active_queries;

  modport source (output valid, active_queries, input ready);
  modport sink   (input valid, active_queries, output ready);
endinterface

// ===== sv/cim_ram.sv =====
// ----------------------------------------------------------------------------
// cim_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cim_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/centroid_interaction_max_sum_top.sv =====
// ----------------------------------------------------------------------------
// centroid_interaction_max_sum_top
// Late-interaction document scorer: per-query running maxima over a
// query-by-centroid score table, summed at the end of each document.
// ----------------------------------------------------------------------------
// Channels: in_if takes load transactions (cmd = load, writes one table
// score) and code transactions (cmd = code, one document centroid code,
// last_code ends the document). out_if returns one match_sum per document.
// cfg_if writes the active query count, which the user must do only while
// the block is idle; the block itself does not enforce this. A load writes
// the table in S_LOAD. A code seen for the first time in the document
// passes S_SEEN_RD and S_SEEN_CHK and then walks the n active queries,
// since one shared compare unit walks the queries, one table read per cycle.
// A repeated code ends after S_SEEN_CHK; an out-of-range code is dropped as it
// is taken. A last code adds a summing pass, which reuses the same query walk.
// The block takes one input transaction at a time; in_if.ready is low
// while a transaction is in progress.
// Reset: all maxima return to the most negative value and the active
// count to 32. The seen-mark memory is then swept over all CENTROIDS entries
// (no input accepted), and the same sweep runs again after every 255
// documents when the document epoch tag wraps.
// Stall: the result sits in an output register; the block keeps taking
// input until a further document end needs that register.
// ----------------------------------------------------------------------------
module centroid_interaction_max_sum_top #(
  parameter int QUERIES   = 32,
  parameter int CENTROIDS = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  cim_in_if.sink        in_if,
  cim_out_if.source     out_if,
  cim_cfg_if.sink       cfg_if
);

  localparam int QW  = (QUERIES > 1) ? $clog2(QUERIES) : 1;
  localparam int NW  = $clog2(QUERIES + 1);
  localparam int CIW = $clog2(CENTROIDS);
  localparam int TAW = $clog2(QUERIES * CENTROIDS);
  localparam int SW  = cim_pkg::SCORE_W + QW + 1;
  localparam int SCW = cim_pkg::SCORE_W;

  // control registers
  cim_pkg::state_t            state_r, state_nxt;
  logic [cim_pkg::ACTIVE_W-1:0] active_r, active_nxt;
  logic [NW-1:0]              n_r, n_nxt;
  logic [NW-1:0]              rd_q_r, rd_q_nxt;
  logic                       pend_r, pend_nxt;
  logic [QW-1:0]              pend_q_r, pend_q_nxt;
  logic [QUERIES-1:0]         qvalid_r, qvalid_nxt;
  logic [cim_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [CIW-1:0]             clr_r, clr_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // payload registers
  logic [CIW-1:0]             col_r, col_nxt;
  logic                       last_r, last_nxt;
  logic [TAW-1:0]             addr_r, addr_nxt;
  logic [SCW-1:0]             ld_score_r, ld_score_nxt;
  logic signed [SW-1:0]       acc_r, acc_nxt;
  logic signed [cim_pkg::DOC_W-1:0] out_data_r, out_data_nxt;

  // memory ports
  logic                       tbl_we;
  logic [SCW-1:0]             tbl_rdata;
  logic                       qm_we;
  logic [QW-1:0]              qm_waddr;
  logic [SCW-1:0]             qm_wdata;
  logic [SCW-1:0]             qm_rdata;
  logic                       seen_we;
  logic [CIW-1:0]             seen_waddr;
  logic [cim_pkg::EPOCH_W-1:0] seen_wdata;
  logic [cim_pkg::EPOCH_W-1:0] seen_rdata;

  // datapath signals
  logic                       in_acc;
  logic [NW-1:0]              n_cur;
  logic signed [SCW-1:0]      tbl_val;
  logic signed [SCW-1:0]      cur_max;
  logic signed [SCW-1:0]      new_max;
  logic signed [31:0]         acc_ext;
  logic signed [cim_pkg::DOC_W-1:0] sum_sat;

  assign in_if.ready = (state_r == cim_pkg::S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.match_sum = out_data_r;

  // active count saturated to the number of query rows
  assign n_cur = (32'(active_r) > QUERIES) ? NW'(QUERIES) : NW'(active_r);

  // shared compare unit: running maximum of the query being retired
  assign tbl_val = tbl_rdata;
  assign cur_max = qvalid_r[pend_q_r] ? qm_rdata : cim_pkg::MOST_NEG;
  assign new_max = (tbl_val > cur_max) ? tbl_val : cur_max;

  // output saturation
  assign acc_ext = 32'(acc_r);
  always_comb begin
    if (acc_ext > cim_pkg::SUM_MAX) begin
      sum_sat = cim_pkg::SUM_MAX[cim_pkg::DOC_W-1:0];
    end else if (acc_ext < cim_pkg::SUM_MIN) begin
      sum_sat = cim_pkg::SUM_MIN[cim_pkg::DOC_W-1:0];
    end else begin
      sum_sat = acc_ext[cim_pkg::DOC_W-1:0];
    end
  end

  // score table, row-major by query
  cim_ram #(.WIDTH(SCW), .DEPTH(QUERIES * CENTROIDS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (addr_r),
    .wdata (ld_score_r),
    .raddr (addr_r),
    .rdata (tbl_rdata)
  );

  // per-query running maxima, gated by qvalid_r
  cim_ram #(.WIDTH(SCW), .DEPTH(QUERIES)) u_qmax (
    .clk   (clk),
    .we    (qm_we),
    .waddr (qm_waddr),
    .wdata (qm_wdata),
    .raddr (rd_q_r[QW-1:0]),
    .rdata (qm_rdata)
  );

  // seen marks as document epoch tags
  cim_ram #(.WIDTH(cim_pkg::EPOCH_W), .DEPTH(CENTROIDS)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (col_r),
    .rdata (seen_rdata)
  );

  // sequencer: next state, counters and memory controls
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    n_nxt         = n_r;
    rd_q_nxt      = rd_q_r;
    pend_nxt      = pend_r;
    pend_q_nxt    = pend_q_r;
    qvalid_nxt    = qvalid_r;
    epoch_nxt     = epoch_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    col_nxt       = col_r;
    last_nxt      = last_r;
    addr_nxt      = addr_r;
    ld_score_nxt  = ld_score_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    tbl_we        = 1'b0;
    qm_we         = 1'b0;
    qm_waddr      = pend_q_r;
    qm_wdata      = new_max;
    seen_we       = 1'b0;
    seen_waddr    = col_r;
    seen_wdata    = epoch_r;

    // configuration write
    if (cfg_if.valid) begin
      active_nxt = cfg_if.active_queries;
    end

    // result taken by the receiver
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      cim_pkg::S_CLEAR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_r;
        seen_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CIW'(CENTROIDS - 1)) begin
          clr_nxt   = '0;
          state_nxt = cim_pkg::S_IDLE;
        end
      end

      cim_pkg::S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_if.last_code;
          n_nxt    = n_cur;
          col_nxt  = CIW'(in_if.centroid);
          rd_q_nxt = '0;
          pend_nxt = 1'b0;
          acc_nxt  = '0;
          if (in_if.cmd == cim_pkg::CMD_LOAD) begin
            ld_score_nxt = in_if.score;
            addr_nxt = TAW'(in_if.query_index) * TAW'(CENTROIDS)
                       + TAW'(in_if.centroid);
            if ((32'(in_if.query_index) < QUERIES)
                && (32'(in_if.centroid) < CENTROIDS)) begin
              state_nxt = cim_pkg::S_LOAD;
            end
          end else if (32'(in_if.centroid) < CENTROIDS) begin
            state_nxt = cim_pkg::S_SEEN_RD;
          end else if (in_if.last_code) begin
            state_nxt = cim_pkg::S_SUM;
          end
        end
      end

      cim_pkg::S_LOAD: begin
        tbl_we    = 1'b1;
        state_nxt = cim_pkg::S_IDLE;
      end

      cim_pkg::S_SEEN_RD: begin
        state_nxt = cim_pkg::S_SEEN_CHK;
      end

      cim_pkg::S_SEEN_CHK: begin
        if (seen_rdata != epoch_r) begin
          // first time in this document: mark and walk the queries
          seen_we   = 1'b1;
          addr_nxt  = TAW'(col_r);
          state_nxt = cim_pkg::S_UPD;
        end else if (last_r) begin
          state_nxt = cim_pkg::S_SUM;
        end else begin
          state_nxt = cim_pkg::S_IDLE;
        end
      end

      cim_pkg::S_UPD: begin
        // retire the query read in the previous cycle
        if (pend_r) begin
          qm_we                = 1'b1;
          qvalid_nxt[pend_q_r] = 1'b1;
        end
        // issue the next table and maximum reads
        if (rd_q_r < n_r) begin
          addr_nxt   = addr_r + TAW'(CENTROIDS);
          rd_q_nxt   = rd_q_r + 1'b1;
          pend_nxt   = 1'b1;
          pend_q_nxt = rd_q_r[QW-1:0];
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            rd_q_nxt  = '0;
            state_nxt = last_r ? cim_pkg::S_SUM : cim_pkg::S_IDLE;
          end
        end
      end

      cim_pkg::S_SUM: begin
        if (pend_r) begin
          acc_nxt = acc_r + SW'(cur_max);
        end
        if (rd_q_r < n_r) begin
          rd_q_nxt   = rd_q_r + 1'b1;
          pend_nxt   = 1'b1;
          pend_q_nxt = rd_q_r[QW-1:0];
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = cim_pkg::S_DONE;
          end
        end
      end

      cim_pkg::S_DONE: begin
        // publish once the output register is free, then open a new document
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sum_sat;
          qvalid_nxt    = '0;
          rd_q_nxt      = '0;
          epoch_nxt     = epoch_r + 1'b1;
          if (epoch_r == {cim_pkg::EPOCH_W{1'b1}}) begin
            epoch_nxt = {{(cim_pkg::EPOCH_W-1){1'b0}}, 1'b1};
            state_nxt = cim_pkg::S_CLEAR;
          end else begin
            state_nxt = cim_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = cim_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cim_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= cim_pkg::ACTIVE_RESET;
      n_r         <= '0;
      rd_q_r      <= '0;
      pend_r      <= 1'b0;
      pend_q_r    <= '0;
      qvalid_r    <= '0;
      epoch_r     <= {{(cim_pkg::EPOCH_W-1){1'b0}}, 1'b1};
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      n_r         <= n_nxt;
      rd_q_r      <= rd_q_nxt;
      pend_r      <= pend_nxt;
      pend_q_r    <= pend_q_nxt;
      qvalid_r    <= qvalid_nxt;
      epoch_r     <= epoch_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    last_r     <= last_nxt;
    addr_r     <= addr_nxt;
    ld_score_r <= ld_score_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
